// ===== src/countdown_timer_bank_assert.svh =====
// Assertion macros used by the countdown timer bank sequencer.
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH
`ifndef SYNTH
`define CDT_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define CDT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define CDT_IMPLY(lbl, a, b, msg)
`define CDT_NEXT(lbl, a, b, msg)
`endif
`endif

// ===== src/cdt_pkg.sv =====
// Types and constants of the countdown timer bank.
package cdt_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = 16;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [2:0] KIND_SET_OK      = 3'd0;
  localparam logic [2:0] KIND_SET_REFUSED = 3'd1;
  localparam logic [2:0] KIND_EXPIRED     = 3'd2;
  localparam logic [2:0] KIND_IDLE_TICK   = 3'd3;
  localparam logic [2:0] KIND_STOPPED     = 3'd4;

  typedef struct packed {
    logic [1:0]       command;
    logic [5:0]       timer_index;
    logic [CNT_W-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [5:0] result_timer;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== src/cdt_count_store.sv =====
// Storage of the remaining tick counts, one entry per timer.
module cdt_count_store (
  input  logic                     clk,
  input  cdt_pkg::mem_req_t        mem_req,
  output logic [cdt_pkg::CNT_W-1:0] mem_rdata
);

  logic [cdt_pkg::CNT_W-1:0] mem [cdt_pkg::NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      mem_rdata <= mem[mem_req.addr];
    end
  end

endmodule

// ===== src/cdt_seq.sv =====
// Command sequencer: active marks, tick scan and the shared decrement unit.
`include "countdown_timer_bank_assert.svh"
module cdt_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  cdt_pkg::in_item_t         in_item,
  output logic                      in_stall,
  input  logic                      push_ok,
  output logic                      push_en,
  output cdt_pkg::out_item_t        push_item,
  output cdt_pkg::mem_req_t         mem_req,
  input  logic [cdt_pkg::CNT_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN_RD = 4'b0010,
    ST_SCAN_EV = 4'b0100,
    ST_FLUSH   = 4'b1000
  } state_t;

  localparam logic [cdt_pkg::IDX_W-1:0] IDX_LAST = cdt_pkg::IDX_W'(cdt_pkg::NUM_TIMERS - 1);

  state_t                          state_r, state_nxt;
  logic [cdt_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [cdt_pkg::IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [cdt_pkg::NUM_TIMERS-1:0]  active_r, active_nxt;
  logic                            accept;
  logic                            in_range;
  logic [cdt_pkg::IDX_W-1:0]       sidx;
  logic                            cur_active;
  logic                            cur_zero;
  logic                            hold;
  logic [cdt_pkg::CNT_W-1:0]       dec_val;

  assign in_range   = ({1'b0, in_item.timer_index} < 7'(cdt_pkg::NUM_TIMERS));
  assign sidx       = in_item.timer_index[cdt_pkg::IDX_W-1:0];
  assign cur_active = active_r[idx_r];
  // Shared unit: one zero compare and one decrement, reused for every timer.
  assign cur_zero   = (mem_rdata == '0);
  assign dec_val    = mem_rdata - cdt_pkg::CNT_W'(1);
  // An expiry must wait when the previous one cannot be handed on yet.
  assign hold       = cur_active && cur_zero && pend_v_r && !push_ok;
  assign in_stall   = (state_r != ST_IDLE) || !push_ok;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    active_nxt   = active_r;
    push_en      = 1'b0;
    push_item    = '0;
    mem_req      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.command)
            cdt_pkg::CMD_SET: begin
              push_en                = 1'b1;
              push_item.result_timer = in_item.timer_index;
              push_item.last_result  = 1'b1;
              if (in_range && !active_r[sidx]) begin
                push_item.result_kind = cdt_pkg::KIND_SET_OK;
                active_nxt[sidx]      = 1'b1;
                mem_req.wr_en         = 1'b1;
                mem_req.addr          = sidx;
                mem_req.wdata         = in_item.delay_ticks;
              end else begin
                push_item.result_kind = cdt_pkg::KIND_SET_REFUSED;
              end
            end
            cdt_pkg::CMD_STOP: begin
              push_en                = 1'b1;
              push_item.result_kind  = cdt_pkg::KIND_STOPPED;
              push_item.result_timer = in_item.timer_index;
              push_item.last_result  = 1'b1;
              if (in_range) begin
                active_nxt[sidx] = 1'b0;
              end
            end
            cdt_pkg::CMD_TICK: begin
              state_nxt  = ST_SCAN_RD;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = idx_r;
        state_nxt     = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (!hold) begin
          if (cur_active && !cur_zero) begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = idx_r;
            mem_req.wdata = dec_val;
          end else if (cur_active) begin
            active_nxt[idx_r] = 1'b0;
            // The held expiry is not the last one, since another just followed.
            if (pend_v_r) begin
              push_en                = 1'b1;
              push_item.result_kind  = cdt_pkg::KIND_EXPIRED;
              push_item.result_timer = 6'(pend_idx_r);
              push_item.last_result  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + cdt_pkg::IDX_W'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (push_ok) begin
          push_en               = 1'b1;
          push_item.last_result = 1'b1;
          if (pend_v_r) begin
            push_item.result_kind  = cdt_pkg::KIND_EXPIRED;
            push_item.result_timer = 6'(pend_idx_r);
          end else begin
            push_item.result_kind = cdt_pkg::KIND_IDLE_TICK;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      pend_v_r <= 1'b0;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
  end

  `CDT_IMPLY(a_pend_only_in_tick, pend_v_r, state_r != ST_IDLE, "pending expiry outside a tick")
  `CDT_NEXT(a_flush_ends, state_r == ST_FLUSH && push_ok, state_r == ST_IDLE, "flush did not end")
  `CDT_IMPLY(a_scan_push_has_pend, state_r == ST_SCAN_EV && push_en, pend_v_r, "stray push")
  `CDT_NEXT(a_tick_starts_scan, accept && in_item.command == cdt_pkg::CMD_TICK,
            state_r == ST_SCAN_RD && idx_r == '0, "tick did not start scan")

endmodule

// ===== src/countdown_timer_bank.sv =====
// Bank of one-shot countdown timers; a tick scans the timers one at a time.
// Set and stop: result registered, shown in the cycle after the item is accepted.
// Tick: a read state then an evaluate state per timer, set by the count store's single port.
// One item is in work at a time; output stalls stretch a tick's scan.
// Reset clears the active marks and the sequencer; counts are written before use.
module countdown_timer_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cdt_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output cdt_pkg::out_item_t out_item,
  input  logic               out_stall
);

  logic                      out_valid_r;
  cdt_pkg::out_item_t        out_item_r;
  logic                      push_ok;
  logic                      push_en;
  cdt_pkg::out_item_t        push_item;
  cdt_pkg::mem_req_t         mem_req;
  logic [cdt_pkg::CNT_W-1:0] mem_rdata;

  // The output register can take a new item when empty or being drained.
  assign push_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  cdt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .push_ok   (push_ok),
    .push_en   (push_en),
    .push_item (push_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  cdt_count_store u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      out_item_r <= push_item;
    end
  end

endmodule
